[rtl/ttlp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlp_pkg
// Shared types, codes and character tables of the tagged text line parser.
// ----------------------------------------------------------------------------
package ttlp_pkg;

	// parse modes
	localparam logic [2:0] MODE_TYPE = 3'd0;
	localparam logic [2:0] MODE_TAG  = 3'd1;
	localparam logic [2:0] MODE_VPRE = 3'd2;
	localparam logic [2:0] MODE_VIN  = 3'd3;
	localparam logic [2:0] MODE_VESC = 3'd4;
	localparam logic [2:0] MODE_DONE = 3'd5;
	localparam logic [2:0] MODE_FAIL = 3'd6;

	// error codes
	localparam logic [2:0] ERR_NONE       = 3'd0;
	localparam logic [2:0] ERR_EARLY_END  = 3'd1;
	localparam logic [2:0] ERR_TOKEN_CHAR = 3'd2;
	localparam logic [2:0] ERR_TOKEN_LONG = 3'd3;
	localparam logic [2:0] ERR_NO_QUOTE   = 3'd4;
	localparam logic [2:0] ERR_VALUE_CHAR = 3'd5;
	localparam logic [2:0] ERR_VALUE_LONG = 3'd6;
	localparam logic [2:0] ERR_EXTRA      = 3'd7;

	// character kinds
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_TYPE  = 2'd1;
	localparam logic [1:0] KIND_TAG   = 2'd2;
	localparam logic [1:0] KIND_VALUE = 2'd3;

	// register indexes
	localparam logic REG_TOKEN_LIMIT   = 1'b0;
	localparam logic REG_MESSAGE_LIMIT = 1'b1;

	localparam logic [7:0] TOKEN_LIMIT_RST   = 8'd64;
	localparam logic [7:0] MESSAGE_LIMIT_RST = 8'd200;

	// characters
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	localparam logic [2:0] ERROR_LEN = 3'd5;
	localparam logic [2:0] MESG_LEN  = 3'd4;

	typedef struct packed {
		logic [7:0] token_limit;
		logic [7:0] message_limit;
	} limits_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] count;
		logic [2:0] type_pos;
		logic       type_mis;
		logic [2:0] tag_pos;
		logic       tag_mis;
		logic [2:0] err;
	} parse_state_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic [1:0] char_kind;
		logic       field_done;
		logic       packet_done;
		logic       packet_ok;
		logic [2:0] error_code;
	} step_result_t;

	function automatic logic is_token_char(input logic [7:0] ch);
		return (ch == CH_UNDER) || (ch >= 8'h30 && ch <= 8'h39) ||
			(ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
	endfunction

	// "Error"
	function automatic logic [7:0] error_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h45;
			3'd1: c = 8'h72;
			3'd2: c = 8'h72;
			3'd3: c = 8'h6F;
			3'd4: c = 8'h72;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// "mesg"
	function automatic logic [7:0] mesg_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = 8'h6D;
			3'd1: c = 8'h65;
			3'd2: c = 8'h73;
			3'd3: c = 8'h67;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[rtl/ttlp_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlp_cfg
// Limit registers of the parser, written through the configuration channel.
// ----------------------------------------------------------------------------
module ttlp_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [7:0]        cfg_data,
	output ttlp_pkg::limits_t limits
);
	import ttlp_pkg::*;

	limits_t limits_q;

	assign cfg_ready = 1'b1;
	assign limits    = limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.token_limit   <= TOKEN_LIMIT_RST;
			limits_q.message_limit <= MESSAGE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TOKEN_LIMIT:   limits_q.token_limit   <= cfg_data;
				REG_MESSAGE_LIMIT: limits_q.message_limit <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

[rtl/ttlp_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlp_step
// Next-state and result logic for one byte of the line.
// ----------------------------------------------------------------------------
module ttlp_step (
	input  ttlp_pkg::parse_state_t cur,
	input  logic [7:0]             ch,
	input  logic                   last,
	input  ttlp_pkg::limits_t      limits,
	output ttlp_pkg::parse_state_t nxt,
	output ttlp_pkg::step_result_t res
);
	import ttlp_pkg::*;

	logic       is_end;
	logic       special;
	logic [7:0] vlimit;
	logic [1:0] kind;
	logic       fdone;
	logic       ok;
	logic [2:0] code;
	parse_state_t st;

	assign is_end  = (ch == CH_CR) || (ch == CH_LF) ||
		(ch == CH_SPACE && cur.count != 8'd0);
	assign special = (cur.type_pos == ERROR_LEN) && !cur.type_mis &&
		(cur.tag_pos == MESG_LEN) && !cur.tag_mis;
	assign vlimit  = special ? limits.message_limit : limits.token_limit;

	always_comb begin
		st    = cur;
		kind  = KIND_NONE;
		fdone = 1'b0;
		ok    = 1'b0;
		code  = ERR_NONE;
		case (cur.mode) inside
			MODE_TYPE, MODE_TAG: begin
				if (is_end) begin
					if (cur.mode == MODE_TYPE || cur.count != 8'd0) begin
						fdone = 1'b1;
					end
					if (cur.mode == MODE_TYPE || cur.count == 8'd0) begin
						// tag start, or end of line on an empty tag
						st.mode    = (cur.mode == MODE_TYPE) ? MODE_TAG : MODE_DONE;
						st.count   = (cur.mode == MODE_TYPE) ? 8'd0 : cur.count;
						st.tag_pos = (cur.mode == MODE_TYPE) ? 3'd0 : cur.tag_pos;
						st.tag_mis = (cur.mode == MODE_TYPE) ? 1'b0 : cur.tag_mis;
					end else begin
						st.mode = MODE_VPRE;
					end
				end else if (ch == CH_SPACE) begin
					// skip leading space
				end else if (!is_token_char(ch)) begin
					st.mode = MODE_FAIL;
					st.err  = ERR_TOKEN_CHAR;
				end else if (cur.count >= limits.token_limit) begin
					st.mode = MODE_FAIL;
					st.err  = ERR_TOKEN_LONG;
				end else begin
					st.count = cur.count + 8'd1;
					if (cur.mode == MODE_TYPE) begin
						kind = KIND_TYPE;
						if (!cur.type_mis) begin
							if (cur.type_pos < ERROR_LEN && error_char(cur.type_pos) == ch)
								st.type_pos = cur.type_pos + 3'd1;
							else
								st.type_mis = 1'b1;
						end
					end else begin
						kind = KIND_TAG;
						if (!cur.tag_mis) begin
							if (cur.tag_pos < MESG_LEN && mesg_char(cur.tag_pos) == ch)
								st.tag_pos = cur.tag_pos + 3'd1;
							else
								st.tag_mis = 1'b1;
						end
					end
				end
			end
			MODE_VPRE: begin
				if (ch == CH_QUOTE) begin
					st.mode  = MODE_VIN;
					st.count = 8'd0;
				end else if (ch != CH_SPACE) begin
					st.mode = MODE_FAIL;
					st.err  = ERR_NO_QUOTE;
				end
			end
			MODE_VIN, MODE_VESC: begin
				if (ch < CH_SPACE || ch > CH_TILDE) begin
					st.mode = MODE_FAIL;
					st.err  = ERR_VALUE_CHAR;
				end else if (cur.mode == MODE_VIN && ch == CH_BSL) begin
					st.mode = MODE_VESC;
				end else if (cur.mode == MODE_VIN && ch == CH_QUOTE) begin
					fdone       = 1'b1;
					st.mode     = MODE_TAG;
					st.count    = 8'd0;
					st.tag_pos  = 3'd0;
					st.tag_mis  = 1'b0;
				end else if (cur.count >= vlimit) begin
					st.mode = MODE_FAIL;
					st.err  = ERR_VALUE_LONG;
				end else begin
					st.count = cur.count + 8'd1;
					st.mode  = MODE_VIN;
					kind     = KIND_VALUE;
				end
			end
			MODE_DONE: begin
				st.mode = MODE_FAIL;
				st.err  = ERR_EXTRA;
			end
			default: ;
		endcase

		if (last) begin
			if (st.err != ERR_NONE)
				code = st.err;
			else if (st.mode == MODE_DONE)
				ok = 1'b1;
			else
				code = ERR_EARLY_END;
		end

		nxt = last ? '0 : st;

		res.out_char    = (kind != KIND_NONE) ? ch : 8'd0;
		res.char_kind   = kind;
		res.field_done  = fdone;
		res.packet_done = last;
		res.packet_ok   = ok;
		res.error_code  = code;
	end

endmodule

[rtl/tagged_text_line_parser.sv]
`timescale 1ns / 1ps
// A byte transaction reaches the result through the input register, then the result register.
// Throughput: one byte per cycle, sustained while the result side does not stall.
// The single parse-state register closes the per-byte loop.
// Reset (arst_n low, asynchronous): empty pipeline, parser at start of the type
// token, token_limit = 64, message_limit = 200.
// ----------------------------------------------------------------------------
// tagged_text_line_parser
// Streams a tagged text line byte by byte, emits accepted characters and the
// packet outcome on the last byte.
// ----------------------------------------------------------------------------
module tagged_text_line_parser (
	input  logic       clk,
	input  logic       arst_n,
	// configuration channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	// byte channel
	input  logic       data_valid,
	output logic       data_stall,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	// result channel
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_char,
	output logic [1:0] char_kind,
	output logic       field_done,
	output logic       packet_done,
	output logic       packet_ok,
	output logic [2:0] error_code
);
	import ttlp_pkg::*;

	limits_t      limits;
	parse_state_t state_q;
	parse_state_t state_nxt;
	step_result_t res;
	step_result_t res_s2;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       valid_s2;
	logic       adv;

	// Limit registers; always ready, so write them only while no byte is in
	// flight.
	ttlp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.limits    (limits)
	);

	// Parse the held byte against the current state.
	ttlp_step u_step (
		.cur    (state_q),
		.ch     (byte_s1),
		.last   (last_s1),
		.limits (limits),
		.nxt    (state_nxt),
		.res    (res)
	);

	// Advance the held byte when the result register is empty or draining.
	assign adv        = valid_s1 && (!valid_s2 || !result_stall);
	// Stall the byte side only when the input register is full and cannot move.
	assign data_stall = valid_s1 && !adv;

	// Input register: take a new transaction whenever it is not stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!data_stall) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && !data_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Parse state: update once per advanced byte; the step logic clears it on
	// the last byte of a packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// Result register: hold while stalled, drop after its transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign out_char     = res_s2.out_char;
	assign char_kind    = res_s2.char_kind;
	assign field_done   = res_s2.field_done;
	assign packet_done  = res_s2.packet_done;
	assign packet_ok    = res_s2.packet_ok;
	assign error_code   = res_s2.error_code;

`ifndef ASSERT_OFF
	// A clean outcome only comes with the packet end and no error code.
	a_ok_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.packet_ok) |->
			(res_s2.packet_done && res_s2.error_code == ERR_NONE))
		else $error("packet_ok without clean packet end");

	// No character is shown unless it was accepted into a field.
	a_char_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.char_kind == KIND_NONE) |-> (res_s2.out_char == 8'd0))
		else $error("character shown without a kind");

	// After the last byte the parser is back at the start of a line.
	a_packet_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && last_s1) |=> (state_q.mode == MODE_TYPE && state_q.err == ERR_NONE))
		else $error("parse state not cleared after packet end");

	// A latched error holds the parser in the fail mode until the packet ends.
	a_fail_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.err != ERR_NONE) |-> (state_q.mode == MODE_FAIL))
		else $error("error latched outside fail mode");
`endif

endmodule
